// ----- src/bbt_pkg.sv -----
// Package for the Bollinger band tracker: window constants, derived widths,
// and the packed request and response word types.
// No dependencies; the other files in src, bbt_ram apart, refer to it by scoped names.
package bbt_pkg;

   // Window length and fixed field widths.
   localparam int WINDOW      = 20;
   localparam int DATA_W      = 24;
   localparam int MULT_W      = 4;
   localparam logic [MULT_W-1:0] MULT_RESET = 4'd2;
   localparam logic [DATA_W-1:0] FULL_SCALE = {DATA_W{1'b1}};

   // Ring addressing and fill count.
   localparam int ADDR_W      = $clog2(WINDOW);
   localparam int CNT_W       = $clog2(WINDOW + 1);

   // Running sums and the variance numerator.
   localparam int SUM_W       = DATA_W + $clog2(WINDOW);
   localparam int SQ_W        = 2 * DATA_W + $clog2(WINDOW);
   localparam int NUM_W       = 2 * SUM_W;
   localparam int VAR_W       = 2 * DATA_W;
   localparam int SPAN_W      = DATA_W + MULT_W;

   // Constant-divisor long division, several quotient bits per cycle.
   localparam int VAR_DIVISOR = WINDOW * (WINDOW - 1);
   localparam int DIVR_W      = $clog2(VAR_DIVISOR + 1);
   localparam int DIV_STEPS   = 4;
   localparam int DIV_CYCLES  = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
   localparam int DIV_W       = DIV_CYCLES * DIV_STEPS;
   localparam int DIV_CNT_W   = $clog2(DIV_CYCLES + 1);

   // Digit-by-digit square root, two root bits per cycle.
   localparam int ROOT_W      = DATA_W;
   localparam int SQRT_STEPS  = 2;
   localparam int SQRT_CYCLES = ROOT_W / SQRT_STEPS;
   localparam int SQRT_CNT_W  = $clog2(SQRT_CYCLES + 1);
   localparam int REM_W       = ROOT_W + 3;

   typedef struct packed {
      logic [DATA_W-1:0] price_sample;
      logic [DATA_W-1:0] bar_high;
      logic [DATA_W-1:0] bar_low;
   } req_word_type;

   typedef struct packed {
      logic              window_full;
      logic [DATA_W-1:0] band_mean;
      logic [DATA_W-1:0] band_deviation;
      logic [DATA_W-1:0] upper_band;
      logic [DATA_W-1:0] lower_band;
      logic              low_touch;
      logic              high_touch;
   } rsp_word_type;

endpackage

// ----- src/bbt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bbt_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 20
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      if (read_enable) begin
         rdata_ff <= mem_ff[read_address];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/bbt_div.sv -----
// Restoring long division by a fixed divisor, DIV_STEPS quotient bits a cycle.
// Depends on bbt_pkg for widths and the step count.
module bbt_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [bbt_pkg::DIV_W-1:0]  dividend,
   input  logic [bbt_pkg::DIVR_W-1:0] divisor,
   output logic                       done,
   output logic [bbt_pkg::DIV_W-1:0]  quotient
);

   logic [bbt_pkg::DIV_W-1:0]     work_ff, work_in;
   logic [bbt_pkg::DIVR_W-1:0]    rem_ff, rem_in;
   logic [bbt_pkg::DIV_CNT_W-1:0] count_ff, count_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;

   always_comb begin
      logic [bbt_pkg::DIVR_W:0]   trial;
      logic [bbt_pkg::DIV_W-1:0]  work;
      trial    = '0;
      work     = work_ff;
      rem_in   = rem_ff;
      work_in  = work_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         work_in  = dividend;
         rem_in   = '0;
         count_in = bbt_pkg::DIV_CNT_W'(bbt_pkg::DIV_CYCLES);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         trial = {1'b0, rem_ff};
         for (int k = 0; k < bbt_pkg::DIV_STEPS; k++) begin
            trial = {trial[bbt_pkg::DIVR_W-1:0], work[bbt_pkg::DIV_W-1]};
            work  = {work[bbt_pkg::DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
               trial   = trial - {1'b0, divisor};
               work[0] = 1'b1;
            end
         end
         work_in  = work;
         rem_in   = trial[bbt_pkg::DIVR_W-1:0];
         count_in = count_ff - 1'b1;
         if (count_ff == bbt_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = work_ff;

endmodule

// ----- src/bbt_sqrt.sv -----
// Truncated integer square root, digit by digit, SQRT_STEPS root bits a cycle.
// Depends on bbt_pkg for widths and the step count.
module bbt_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [bbt_pkg::VAR_W-1:0]   radicand,
   output logic                        done,
   output logic [bbt_pkg::ROOT_W-1:0]  root
);

   logic [bbt_pkg::VAR_W-1:0]      rad_ff, rad_in;
   logic [bbt_pkg::REM_W-1:0]      rem_ff, rem_in;
   logic [bbt_pkg::ROOT_W-1:0]     root_ff, root_in;
   logic [bbt_pkg::SQRT_CNT_W-1:0] count_ff, count_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;

   always_comb begin
      logic [bbt_pkg::REM_W-1:0]  rem;
      logic [bbt_pkg::REM_W-1:0]  trial;
      logic [bbt_pkg::VAR_W-1:0]  rad;
      logic [bbt_pkg::ROOT_W-1:0] res;
      rem      = rem_ff;
      trial    = '0;
      rad      = rad_ff;
      res      = root_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rad_in   = radicand;
         rem_in   = '0;
         root_in  = '0;
         count_in = bbt_pkg::SQRT_CNT_W'(bbt_pkg::SQRT_CYCLES);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         for (int k = 0; k < bbt_pkg::SQRT_STEPS; k++) begin
            // Bring down the next pair of radicand bits and try root*4 + 1.
            rem   = {rem[bbt_pkg::REM_W-3:0], rad[bbt_pkg::VAR_W-1 -: 2]};
            rad   = {rad[bbt_pkg::VAR_W-3:0], 2'b00};
            trial = {res[bbt_pkg::REM_W-4:0], 2'b01};
            if (rem >= trial) begin
               rem = rem - trial;
               res = {res[bbt_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               res = {res[bbt_pkg::ROOT_W-2:0], 1'b0};
            end
         end
         rad_in   = rad;
         rem_in   = rem;
         root_in  = res;
         count_in = count_ff - 1'b1;
         if (count_ff == bbt_pkg::SQRT_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ----- src/bollinger_band_tracker.sv -----
// Top level of the Bollinger band tracker: sample ring, running sums, control.
// Depends on bbt_pkg, bbt_ram, bbt_div and bbt_sqrt.
//
//   Channel   Ports                              Role
//   request   req_valid req_ready req_word       price sample with bar high and low
//   response  rsp_valid rsp_ready rsp_word       mean, deviation, bands, touch flags
//   control   csr_write_enable csr_write_data    band multiplier, written at once
//
// One word is in work at a time. While the window is still filling, a word goes
// through the ring update, the sums and the emit state only. With a full window it
// also passes the moment products, the variance and mean divides (four quotient bits
// at a time), the square root (two root bits at a time) and the band arithmetic.
// Reset is synchronous; it empties the window, clears both sums and sets the
// multiplier to two. The ring memory is not cleared: the fill count keeps any
// entry from being read before it is written.
// A stalled response waits in the output register, and a new request word is
// taken meanwhile; only the final write of the next result waits for it to drain.

module bollinger_band_tracker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  bbt_pkg::req_word_type        req_word,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output bbt_pkg::rsp_word_type        rsp_word,
   input  logic                         csr_write_enable,
   input  logic [bbt_pkg::MULT_W-1:0]   csr_write_data
);

   // The sequencer walks one word through the ring update, the sums, the two
   // divides, the root and the band arithmetic, one step per state.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_MOMENT,
      ST_DIFF,
      ST_DIVIDE,
      ST_ROOT,
      ST_SPAN,
      ST_EDGE,
      ST_EMIT
   } state_type;

   // Control registers.
   state_type                     state_ff, state_in;
   logic [bbt_pkg::ADDR_W-1:0]    wpos_ff, wpos_in;
   logic [bbt_pkg::CNT_W-1:0]     fill_ff, fill_in;
   logic [bbt_pkg::SUM_W-1:0]     sum_ff, sum_in;
   logic [bbt_pkg::SQ_W-1:0]      sq_ff, sq_in;
   logic [bbt_pkg::MULT_W-1:0]    mult_ff, mult_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   bbt_pkg::req_word_type         item_ff, item_in;
   logic                          full_ff, full_in;
   logic [bbt_pkg::DATA_W-1:0]    old_ff, old_in;
   logic [bbt_pkg::VAR_W-1:0]     old_sq_ff, old_sq_in;
   logic [bbt_pkg::VAR_W-1:0]     new_sq_ff, new_sq_in;
   logic [bbt_pkg::NUM_W-1:0]     sum_sq_ff, sum_sq_in;
   logic [bbt_pkg::NUM_W-1:0]     wsq_ff, wsq_in;
   logic [bbt_pkg::DATA_W-1:0]    mean_ff, mean_in;
   logic [bbt_pkg::DATA_W-1:0]    dev_ff, dev_in;
   logic [bbt_pkg::SPAN_W-1:0]    span_ff, span_in;
   logic [bbt_pkg::DATA_W-1:0]    upper_ff, upper_in;
   logic [bbt_pkg::DATA_W-1:0]    lower_ff, lower_in;
   bbt_pkg::rsp_word_type         rsp_word_ff, rsp_word_in;

   // Datapath nets.
   logic                          accept;
   logic                          replace;
   logic [bbt_pkg::DATA_W-1:0]    ram_rdata;
   logic [bbt_pkg::DATA_W-1:0]    old_value;
   logic                          div_start;
   logic                          var_done, mean_done;
   logic [bbt_pkg::DIV_W-1:0]     var_quot, mean_quot;
   logic                          root_start;
   logic                          root_done;
   logic [bbt_pkg::ROOT_W-1:0]    root_value;
   logic [bbt_pkg::SPAN_W:0]      upper_sum;
   logic                          low_touch;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Once the window is full, the slot about to be overwritten holds the
   // oldest sample, which leaves both sums as the new sample enters.
   assign replace   = (fill_ff == bbt_pkg::CNT_W'(bbt_pkg::WINDOW));
   assign old_value = replace ? ram_rdata : '0;

   bbt_ram #(
      .WIDTH (bbt_pkg::DATA_W),
      .DEPTH (bbt_pkg::WINDOW)
   ) u_ring (
      .clock         (clock),
      .write_enable  (state_ff == ST_SQUARE),
      .write_address (wpos_ff),
      .write_data    (item_ff.price_sample),
      .read_enable   (accept),
      .read_address  (wpos_ff),
      .rdata         (ram_rdata)
   );

   // The variance numerator W*sumsq - sum^2 is never negative, so a plain
   // unsigned divide by W*(W-1) gives the truncated sample variance.
   bbt_div u_var_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (bbt_pkg::DIV_W'(wsq_ff - sum_sq_ff)),
      .divisor  (bbt_pkg::DIVR_W'(bbt_pkg::VAR_DIVISOR)),
      .done     (var_done),
      .quotient (var_quot)
   );

   // The mean uses a second divider of the same length, so both finish together.
   bbt_div u_mean_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (bbt_pkg::DIV_W'(sum_ff)),
      .divisor  (bbt_pkg::DIVR_W'(bbt_pkg::WINDOW)),
      .done     (mean_done),
      .quotient (mean_quot)
   );

   bbt_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (var_quot[bbt_pkg::VAR_W-1:0]),
      .done     (root_done),
      .root     (root_value)
   );

   assign div_start = (state_ff == ST_DIFF);

   // The upper band is formed one bit wider so that saturation can be seen.
   assign upper_sum = (bbt_pkg::SPAN_W + 1)'(mean_ff) + (bbt_pkg::SPAN_W + 1)'(span_ff);
   assign low_touch = (item_ff.bar_low <= lower_ff);

   always_comb begin
      state_in     = state_ff;
      wpos_in      = wpos_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      mult_in      = csr_write_enable ? csr_write_data : mult_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      item_in      = item_ff;
      full_in      = full_ff;
      old_in       = old_ff;
      old_sq_in    = old_sq_ff;
      new_sq_in    = new_sq_ff;
      sum_sq_in    = sum_sq_ff;
      wsq_in       = wsq_ff;
      mean_in      = mean_ff;
      dev_in       = dev_ff;
      span_in      = span_ff;
      upper_in     = upper_ff;
      lower_in     = lower_ff;
      rsp_word_in  = rsp_word_ff;
      root_start   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_word;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            // Ring data for this slot has arrived; the new sample goes in now.
            old_in    = old_value;
            old_sq_in = old_value * old_value;
            new_sq_in = item_ff.price_sample * item_ff.price_sample;
            if (!replace) begin
               fill_in = fill_ff + 1'b1;
            end
            if (wpos_ff == bbt_pkg::ADDR_W'(bbt_pkg::WINDOW - 1)) begin
               wpos_in = '0;
            end else begin
               wpos_in = wpos_ff + 1'b1;
            end
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            sum_in  = sum_ff - bbt_pkg::SUM_W'(old_ff)
                    + bbt_pkg::SUM_W'(item_ff.price_sample);
            sq_in   = sq_ff - bbt_pkg::SQ_W'(old_sq_ff) + bbt_pkg::SQ_W'(new_sq_ff);
            full_in = replace;
            if (replace) begin
               state_in = ST_MOMENT;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_MOMENT: begin
            sum_sq_in = sum_ff * sum_ff;
            wsq_in    = bbt_pkg::NUM_W'(sq_ff) * bbt_pkg::NUM_W'(bbt_pkg::WINDOW);
            state_in  = ST_DIFF;
         end
         ST_DIFF: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (var_done && mean_done) begin
               mean_in    = mean_quot[bbt_pkg::DATA_W-1:0];
               root_start = 1'b1;
               state_in   = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (root_done) begin
               dev_in   = root_value;
               state_in = ST_SPAN;
            end
         end
         ST_SPAN: begin
            span_in  = dev_ff * mult_ff;
            state_in = ST_EDGE;
         end
         ST_EDGE: begin
            if (upper_sum > (bbt_pkg::SPAN_W + 1)'(bbt_pkg::FULL_SCALE)) begin
               upper_in = bbt_pkg::FULL_SCALE;
            end else begin
               upper_in = upper_sum[bbt_pkg::DATA_W-1:0];
            end
            if (span_ff >= bbt_pkg::SPAN_W'(mean_ff)) begin
               lower_in = '0;
            end else begin
               lower_in = mean_ff - span_ff[bbt_pkg::DATA_W-1:0];
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // The result is written only once the previous one has left.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = '0;
               if (full_ff) begin
                  rsp_word_in.window_full    = 1'b1;
                  rsp_word_in.band_mean      = mean_ff;
                  rsp_word_in.band_deviation = dev_ff;
                  rsp_word_in.upper_band     = upper_ff;
                  rsp_word_in.lower_band     = lower_ff;
                  rsp_word_in.low_touch      = low_touch;
                  rsp_word_in.high_touch     = !low_touch
                                             && (item_ff.bar_high >= upper_ff);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wpos_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         mult_ff      <= bbt_pkg::MULT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wpos_ff      <= wpos_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         mult_ff      <= mult_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      full_ff     <= full_in;
      old_ff      <= old_in;
      old_sq_ff   <= old_sq_in;
      new_sq_ff   <= new_sq_in;
      sum_sq_ff   <= sum_sq_in;
      wsq_ff      <= wsq_in;
      mean_ff     <= mean_in;
      dev_ff      <= dev_in;
      span_ff     <= span_in;
      upper_ff    <= upper_in;
      lower_ff    <= lower_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ----- src/bbt_checker.sv -----
// Port-level checks for the Bollinger band tracker, bound to the top level.
// Depends on bbt_pkg and on the port list of bollinger_band_tracker.
module bbt_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input bbt_pkg::rsp_word_type rsp_word
);

   // A response word that is not taken stays, unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed while stalled");

   // Before the window fills, every band field and flag reads as zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.window_full |->
         rsp_word.band_mean == '0 && rsp_word.band_deviation == '0 &&
         rsp_word.upper_band == '0 && rsp_word.lower_band == '0 &&
         !rsp_word.low_touch && !rsp_word.high_touch)
      else $error("nonzero band data while window not full");

   // A low touch always suppresses the high touch.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_word.low_touch && rsp_word.high_touch))
      else $error("both touch flags set");

   // The bands lie on either side of the mean.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.window_full |->
         rsp_word.lower_band <= rsp_word.band_mean &&
         rsp_word.upper_band >= rsp_word.band_mean)
      else $error("bands out of order around the mean");

endmodule

bind bollinger_band_tracker bbt_checker u_bbt_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);

// ----- tb/sv/bollinger_band_tracker_tb.sv -----
// Self-checking testbench for the Bollinger band tracker: drives price bars with gaps and
// response stalls, predicts every response word and compares it field by field.
// Depends on bbt_pkg and the bollinger_band_tracker RTL.
module bollinger_band_tracker_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bbt_pkg::*;

   // The slowest correct run is roughly 1000 words, each with its work, a sender gap
   // and a response stall; the limit is several times that.
   localparam int CYCLE_LIMIT = 600000;
   localparam int TOP_PRICE   = 16777215;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   req_word_type  req_word = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_word_type  rsp_word;
   logic          csr_write_enable = 1'b0;
   logic [MULT_W-1:0] csr_write_data = '0;

   bollinger_band_tracker u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   // Our own copy of the tracker state: the price window, its sums and the multiplier.
   logic [DATA_W-1:0] price_window [WINDOW];
   int                window_slot = 0;
   int                prices_held = 0;
   logic [63:0]       price_sum = '0;
   logic [63:0]       price_square_sum = '0;
   logic [MULT_W-1:0] band_multiplier = MULT_RESET;

   // Expected response words, oldest first.
   rsp_word_type      expected_bands [$];

   int                mismatch_count = 0;
   int                cycle_count = 0;

   // Sender burst control and the price walk that shapes the random bars.
   int                burst_left = 0;
   int                price_level = 25600;
   int                volatility = 8;

   // Receiver stall pattern: one bit per cycle, a fresh pattern once all 16 bits are used.
   logic [15:0]       ready_pattern = '1;
   logic [3:0]        ready_phase = '0;

   task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= 30)
         $display("%0t mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
   endtask

   // Computes the response that one accepted word must produce and advances the
   // window. The oldest price leaves both sums once the window is full, the mean
   // and the variance are truncated, and the root is found bit by bit from the top.
   function automatic rsp_word_type predict_bands(req_word_type bar);
      rsp_word_type bands;
      logic [63:0]  oldest, mean, numerator, variance, deviation, trial, span, upper, lower;
      bands = '0;
      if (prices_held == WINDOW) begin
         oldest = 64'(price_window[window_slot]);
         price_sum -= oldest;
         price_square_sum -= oldest * oldest;
      end else begin
         prices_held++;
      end
      price_window[window_slot] = bar.price_sample;
      price_sum += 64'(bar.price_sample);
      price_square_sum += 64'(bar.price_sample) * 64'(bar.price_sample);
      window_slot = (window_slot + 1) % WINDOW;
      if (prices_held == WINDOW) begin
         mean = price_sum / 64'(WINDOW);
         numerator = 64'(WINDOW) * price_square_sum - price_sum * price_sum;
         variance = numerator / 64'(WINDOW * (WINDOW - 1));
         deviation = '0;
         for (int b = 31; b >= 0; b--) begin
            trial = deviation | (64'd1 << b);
            if (trial * trial <= variance)
               deviation = trial;
         end
         if (deviation > 64'(FULL_SCALE))
            deviation = 64'(FULL_SCALE);
         span = deviation * 64'(band_multiplier);
         upper = mean + span;
         if (upper > 64'(FULL_SCALE))
            upper = 64'(FULL_SCALE);
         lower = (span >= mean) ? 64'd0 : mean - span;
         bands.window_full    = 1'b1;
         bands.band_mean      = mean[DATA_W-1:0];
         bands.band_deviation = deviation[DATA_W-1:0];
         bands.upper_band     = upper[DATA_W-1:0];
         bands.lower_band     = lower[DATA_W-1:0];
         bands.low_touch      = (64'(bar.bar_low) <= lower);
         bands.high_touch     = !bands.low_touch && (64'(bar.bar_high) >= upper);
      end
      return bands;
   endfunction

   // Every accepted request word gets its prediction queued at the accepting edge.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         expected_bands.push_back(predict_bands(req_word));
   end

   // Every accepted response word is checked against the oldest prediction.
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bands.size() == 0) begin
            note_mismatch("response with none expected", rsp_word.band_mean, '0);
         end else begin
            want = expected_bands.pop_front();
            if (rsp_word.window_full !== want.window_full)
               note_mismatch("window_full", rsp_word.window_full, want.window_full);
            if (rsp_word.band_mean !== want.band_mean)
               note_mismatch("band_mean", rsp_word.band_mean, want.band_mean);
            if (rsp_word.band_deviation !== want.band_deviation)
               note_mismatch("band_deviation", rsp_word.band_deviation,
                             want.band_deviation);
            if (rsp_word.upper_band !== want.upper_band)
               note_mismatch("upper_band", rsp_word.upper_band, want.upper_band);
            if (rsp_word.lower_band !== want.lower_band)
               note_mismatch("lower_band", rsp_word.lower_band, want.lower_band);
            if (rsp_word.low_touch !== want.low_touch)
               note_mismatch("low_touch", rsp_word.low_touch, want.low_touch);
            if (rsp_word.high_touch !== want.high_touch)
               note_mismatch("high_touch", rsp_word.high_touch, want.high_touch);
         end
      end
   end

   // The receiver walks through a 16-bit ready pattern. A new pattern is picked
   // each time round: no stalls at all, random stalls, or one long stall.
   always @(negedge clock) begin
      if (ready_phase == 4'd0) begin
         case ($urandom_range(0, 3))
            0: begin
               ready_pattern = '1;
            end
            1: begin
               ready_pattern = 16'h8000;
            end
            default: begin
               ready_pattern = 16'($urandom);
            end
         endcase
      end
      rsp_ready <= ready_pattern[ready_phase];
      ready_phase <= ready_phase + 4'd1;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // Sends one word and returns once it has been accepted. Valid stays high into the
   // next word while a burst lasts; at the end of a burst the sender idles a while.
   task automatic send_bar(req_word_type bar);
      @(negedge clock);
      req_valid <= 1'b1;
      req_word  <= bar;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 44)) @(negedge clock);
         burst_left = $urandom_range(0, 30);
      end
   endtask

   // Stops sending and waits until every predicted response has been seen, so the
   // block is idle afterwards.
   task automatic wait_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_bands.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_band_multiplier(logic [MULT_W-1:0] multiplier);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= multiplier;
      band_multiplier   = multiplier;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Random bars. Most follow a price walk whose level and volatility change every
   // forty words, with the bar's high and low spread around the price, so the bands
   // stay meaningful and both touches occur. A few words are pure noise, and some
   // force a bar low of zero or a bar high of full scale.
   task automatic run_bar_items(int count);
      req_word_type bar;
      int           kind, high, low, spread;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            volatility = $urandom_range(0, 18);
            case ($urandom_range(0, 3))
               0: price_level = TOP_PRICE - $urandom_range(0, 65536);
               1: price_level = $urandom_range(0, 65536);
               default: price_level = $urandom_range(0, TOP_PRICE);
            endcase
         end
         kind = $urandom_range(0, 99);
         if (kind < 8) begin
            bar.price_sample = DATA_W'($urandom);
            bar.bar_high     = DATA_W'($urandom);
            bar.bar_low      = DATA_W'($urandom);
         end else begin
            if (kind < 10)
               price_level = $urandom_range(0, TOP_PRICE);
            spread = 1 << volatility;
            if ($urandom_range(0, 1))
               price_level += $urandom_range(0, spread);
            else
               price_level -= $urandom_range(0, spread);
            if (price_level < 0)
               price_level = 0;
            if (price_level > TOP_PRICE)
               price_level = TOP_PRICE;
            high = price_level + $urandom_range(0, spread);
            low  = price_level - $urandom_range(0, spread);
            if (high > TOP_PRICE)
               high = TOP_PRICE;
            if (low < 0)
               low = 0;
            if (kind < 14)
               low = 0;
            else if (kind < 18)
               high = TOP_PRICE;
            bar.price_sample = DATA_W'(price_level);
            bar.bar_high     = DATA_W'(high);
            bar.bar_low      = DATA_W'(low);
         end
         send_bar(bar);
         // Now and then the sender holds off until every response is back.
         if ($urandom_range(0, 59) == 0)
            wait_until_drained();
      end
   endtask

   // A flat window first: bands read zero until the twentieth word, after which the
   // deviation is zero and both bands sit on the mean, so a bar high equal to the
   // mean is a high touch. Then full-scale and zero prices enter and evict the flat
   // ones, driving the lower band to zero, with a bar that touches both bands to show
   // the low touch taking priority.
   task automatic test_window_fill_and_extremes();
      req_word_type bar;
      for (int i = 0; i < WINDOW; i++) begin
         bar.price_sample = 24'h012345;
         bar.bar_high     = 24'h012345;
         bar.bar_low      = 24'h012346;
         send_bar(bar);
      end
      send_bar('{price_sample: FULL_SCALE, bar_high: FULL_SCALE, bar_low: FULL_SCALE});
      send_bar('{price_sample: '0, bar_high: FULL_SCALE, bar_low: '0});
      send_bar('{price_sample: FULL_SCALE, bar_high: '0, bar_low: FULL_SCALE});
      send_bar('{price_sample: '0, bar_high: '0, bar_low: '0});
      send_bar('{price_sample: FULL_SCALE, bar_high: FULL_SCALE, bar_low: '0});
   endtask

   // Random bars with the multiplier still at its reset value.
   task automatic test_reset_multiplier();
      run_bar_items(110);
   endtask

   // The ends of the working range, then zero (bands on the mean) and the largest
   // value that the register holds.
   task automatic test_multiplier_extremes();
      logic [MULT_W-1:0] settings [4] = '{4'd1, 4'd8, 4'd0, 4'd15};
      foreach (settings[i]) begin
         wait_until_drained();
         set_band_multiplier(settings[i]);
         run_bar_items(110);
      end
   endtask

   task automatic test_multiplier_midrange();
      logic [MULT_W-1:0] settings [4] = '{4'd3, 4'd5, 4'd7, 4'd2};
      foreach (settings[i]) begin
         wait_until_drained();
         set_band_multiplier(settings[i]);
         run_bar_items(100);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_window_fill_and_extremes();
      test_reset_multiplier();
      test_multiplier_extremes();
      test_multiplier_midrange();

      wait_until_drained();
      repeat (50) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- bollinger_band_tracker.f -----
src/bbt_pkg.sv
src/bbt_ram.sv
src/bbt_div.sv
src/bbt_sqrt.sv
src/bollinger_band_tracker.sv
src/bbt_checker.sv
tb/sv/bollinger_band_tracker_tb.sv
